>>> hdl/sttt_pkg.sv
// ----------------------------------------------------------------------------
// Timer task table package
// Shared operation codes and the task entry type.
// ----------------------------------------------------------------------------
package sttt_pkg;

   localparam logic [2:0] OP_TICK      = 3'd0;
   localparam logic [2:0] OP_LAUNCH    = 3'd1;
   localparam logic [2:0] OP_ADD       = 3'd2;
   localparam logic [2:0] OP_DEL_ID    = 3'd3;
   localparam logic [2:0] OP_DEL_FIRST = 3'd4;
   localparam logic [2:0] OP_DEL_ALL   = 3'd5;
   localparam logic [2:0] OP_CLEAR     = 3'd6;
   localparam logic [2:0] OP_QUERY     = 3'd7;

   // One task as held by a cell.
   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] handle;
      logic [15:0] delay;
      logic [15:0] period;
      logic [7:0]  repeats;
      logic        endless;
      logic        ready;
   } entry_type;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic        tick;      // apply a tick in place
      logic        load;      // load new entry at the tail slot
      logic        clear;     // drop every entry
      logic        rotate;    // shift the ring down by one slot
      logic        head_drop; // while rotating, slot 0 leaves the ring
   } cell_ctl_type;

endpackage

>>> hdl/sttt_cell.sv
// ----------------------------------------------------------------------------
// Timer task table cell
// Holds one entry; ticks it in place and shifts with its neighbor.
// ----------------------------------------------------------------------------
module sttt_cell
   import sttt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  logic         is_tail,     // this slot is the next free slot
   input  entry_type    new_entry,
   input  entry_type    next_entry,  // from the neighbor above
   input  logic         next_valid,
   input  entry_type    head_entry,  // updated head entry, wraps to the top
   input  logic         is_last_ring, // topmost occupied slot receives the head
   output entry_type    entry,
   output logic         valid
);

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;

   // Next value of the held entry.
   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.tick) begin
         if (entry_ff.delay == 16'd0) entry_in.ready = 1'b1;
         else entry_in.delay = entry_ff.delay - 16'd1;
      end else if (ctl.load && is_tail) begin
         entry_in = new_entry;
         valid_in = 1'b1;
      end else if (ctl.rotate) begin
         if (is_last_ring) begin
            entry_in = head_entry;
            valid_in = !ctl.head_drop;
         end else begin
            entry_in = next_entry;
            valid_in = next_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule

>>> hdl/soft_timer_task_table_top.sv
// ----------------------------------------------------------------------------
// Timer task table
// Table of timed tasks kept in a ring of cells.
// ----------------------------------------------------------------------------
// A tick, add or clear is accepted and its result beat appears in the cycle
// after the accept; with the receiver taking every beat, one such item can be
// accepted per cycle. Launch, delete and query rotate the whole ring of cells
// once, one slot per cycle unless a launch beat waits on the output, and go
// from accept to the next accept through the accept, one scan step per entry,
// the closing beat and the recompute of the tail id. A scan step that emits a
// launch beat, the closing beat and every new item wait while the output
// register still holds a beat the receiver has not taken. The ring keeps
// table order: each rotation step looks at slot 0, emits a result if needed,
// and moves it to the top (or drops it). Payloads are undefined until written.
module soft_timer_task_table_top
   import sttt_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: task_handle, start_delay, run_period, repeat_count, endless,
   // task_id (lowest bit first), zero filled to 72 bits
   input  logic [71:0] req_tdata,
   input  logic [2:0]  req_tuser,  // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: run_handle, result_id, success, repeats_left (lowest bit first),
   // zero filled to 40 bits
   output logic [39:0] rsp_tdata,
   output logic        rsp_tuser,  // launched
   output logic        rsp_tlast
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] left_ff, left_in;   // entries not yet examined
   logic [CW-1:0] len_ff, len_in;     // entries in the ring this pass
   logic [2:0]    op_ff, op_in;
   logic [15:0]   hnd_ff, hnd_in;
   logic [7:0]    tid_ff, tid_in;
   logic          done_ff, done_in;   // first-match ops have matched
   logic          any_ff, any_in;     // launch emitted something
   logic          ok_ff, ok_in;
   logic [7:0]    rep_ff, rep_in;
   logic [7:0]    lastid_ff, lastid_in;

   // Output stage.
   logic          ov_ff, ov_in;
   logic          ola_ff, ola_in, olast_ff, olast_in, ook_ff, ook_in;
   logic [15:0]   oh_ff, oh_in;
   logic [7:0]    oid_ff, oid_in, orep_ff, orep_in;

   cell_ctl_type  ctl;
   entry_type     ents [TABLE_DEPTH];
   logic          vals [TABLE_DEPTH];
   entry_type     head_upd, new_entry;
   logic          hdrop, emit;

   wire accept = req_tvalid && req_tready;
   wire out_free = !ov_ff || rsp_tready;
   wire scanning = (state_ff == ST_SCAN) && left_ff != '0;
   // A scan step needs the output stage when it emits a result.
   wire step = scanning && (!emit || out_free);

   entry_type h;
   assign h = ents[0];

   // Decide what happens to the head entry during one scan step.
   always_comb begin
      head_upd = h;
      hdrop = 1'b0;
      emit = 1'b0;
      unique case (op_ff)
         OP_LAUNCH: if (h.ready) begin
            emit = 1'b1;
            head_upd.ready = 1'b0;
            head_upd.delay = h.period;
            if (!h.endless) begin
               if (h.repeats > 8'd1) head_upd.repeats = h.repeats - 8'd1;
               else hdrop = 1'b1;
            end
         end
         OP_DEL_ID:    hdrop = !done_ff && h.id == tid_ff;
         OP_DEL_FIRST: hdrop = !done_ff && h.handle == hnd_ff;
         OP_DEL_ALL:   hdrop = h.handle == hnd_ff;
         default: ;
      endcase
   end

   assign new_entry = '{id: (count_ff == '0) ? 8'd1 : lastid_ff + 8'd1,
                        handle: req_tdata[15:0], delay: req_tdata[31:16],
                        period: req_tdata[47:32], repeats: req_tdata[55:48],
                        endless: req_tdata[56], ready: 1'b0};

   always_comb begin
      ctl = '0;
      ctl.tick = accept && req_tuser == OP_TICK;
      ctl.clear = accept && req_tuser == OP_CLEAR;
      ctl.load = accept && req_tuser == OP_ADD && count_ff < CW'(TABLE_DEPTH);
      ctl.rotate = step;
      ctl.head_drop = hdrop;
   end

   // Row of cells; slot len-1 receives the wrapped head.
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      entry_type nx;
      logic      nv;
      if (g + 1 < TABLE_DEPTH) begin : g_n
         assign nx = ents[g+1];
         assign nv = vals[g+1];
      end else begin : g_t
         assign nx = ents[g];
         assign nv = 1'b0;
      end
      sttt_cell u_cell (
         .clock(clock), .reset(reset), .ctl(ctl),
         .is_tail(count_ff[CW-1:0] == CW'(g)),
         .new_entry(new_entry), .next_entry(nx), .next_valid(nv),
         .head_entry(head_upd), .is_last_ring(len_ff == CW'(g + 1)),
         .entry(ents[g]), .valid(vals[g])
      );
   end

   assign req_tready = (state_ff == ST_IDLE) && out_free;

   always_comb begin
      state_in = state_ff; count_in = count_ff; left_in = left_ff; len_in = len_ff;
      op_in = op_ff; hnd_in = hnd_ff; tid_in = tid_ff; done_in = done_ff;
      any_in = any_ff; ok_in = ok_ff; rep_in = rep_ff; lastid_in = lastid_ff;
      ov_in = ov_ff && !rsp_tready;
      ola_in = ola_ff; olast_in = olast_ff; ook_in = ook_ff;
      oh_in = oh_ff; oid_in = oid_ff; orep_in = orep_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) begin
            op_in = req_tuser; hnd_in = req_tdata[15:0]; tid_in = req_tdata[64:57];
            done_in = 1'b0; any_in = 1'b0; ok_in = 1'b0; rep_in = 8'd0;
            left_in = count_ff; len_in = count_ff;
            if (req_tuser == OP_TICK || req_tuser == OP_ADD
                || req_tuser == OP_CLEAR) begin
               ov_in = 1'b1; ola_in = 1'b0; olast_in = 1'b1; oh_in = 16'd0;
               orep_in = 8'd0; ook_in = 1'b0; oid_in = 8'd0;
               if (ctl.load) begin
                  ook_in = 1'b1; oid_in = new_entry.id; lastid_in = new_entry.id;
                  count_in = count_ff + CW'(1);
               end
               if (ctl.clear) count_in = '0;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (left_ff == '0) begin
               if (out_free) begin
                  if (op_ff != OP_LAUNCH || !any_ff) begin
                     ov_in = 1'b1; ola_in = 1'b0; oh_in = 16'd0; oid_in = 8'd0;
                     ook_in = ok_ff; orep_in = rep_ff; olast_in = 1'b1;
                  end
                  state_in = ST_OUT;
               end
            end else if (step) begin
               left_in = left_ff - CW'(1);
               if (hdrop) begin
                  len_in = len_ff - CW'(1); count_in = count_ff - CW'(1);
                  ok_in = 1'b1; done_in = 1'b1;
               end
               if (op_ff == OP_QUERY && !done_ff && h.id == tid_ff) begin
                  done_in = 1'b1; ok_in = 1'b1; rep_in = h.repeats;
               end
               if (emit) begin
                  any_in = 1'b1; ov_in = 1'b1; ola_in = 1'b1; oh_in = h.handle;
                  oid_in = h.id; ook_in = 1'b0; orep_in = 8'd0;
                  olast_in = 1'b1;
                  // A later ready entry in this pass means this beat is not last.
                  for (int k = 1; k < TABLE_DEPTH; k++)
                     if (CW'(k) < left_ff && ents[k].ready) olast_in = 1'b0;
               end
            end
         end
         default: begin
            // Recompute the tail id after the pass.
            if (count_ff != '0) lastid_in = ents[IW'(count_ff - CW'(1))].id;
            state_in = ST_IDLE;
         end
      endcase
      ok_in = ok_in && op_ff != OP_LAUNCH;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; count_ff <= '0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; ov_ff <= ov_in;
      end
      left_ff <= left_in; len_ff <= len_in; op_ff <= op_in; hnd_ff <= hnd_in;
      tid_ff <= tid_in; done_ff <= done_in; any_ff <= any_in; ok_ff <= ok_in;
      rep_ff <= rep_in; lastid_ff <= lastid_in; ola_ff <= ola_in;
      olast_ff <= olast_in; ook_ff <= ook_in; oh_ff <= oh_in; oid_ff <= oid_in;
      orep_ff <= orep_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = {7'd0, orep_ff, ook_ff, oid_ff, oh_ff};
   assign rsp_tuser = ola_ff;
   assign rsp_tlast = olast_ff;

endmodule
